// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define B2Y_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define B2Y_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define B2Y_ASSERT(label, clk, rst_n, prop, msg)

`define B2Y_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/b2y_pkg.sv -----
// ----------------------------------------------------------------------------
// b2y_pkg
// constants and helpers for the bgra to ycbcr 4:2:0 converter
// ----------------------------------------------------------------------------
package b2y_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int SUM_W      = 9;
    localparam int LINE_W     = 3 * SUM_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);
    localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(MAX_HEIGHT);

    localparam logic [7:0] LUMA_MIN   = 8'd16;
    localparam logic [7:0] LUMA_MAX   = 8'd235;
    localparam logic [7:0] CHROMA_MIN = 8'd16;
    localparam logic [7:0] CHROMA_MAX = 8'd240;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic logic [CFG_W-1:0] effective_size(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] maxv
    );
        logic [CFG_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = CFG_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    // floor-shifted chroma term plus offset, clamped to video range
    function automatic logic [7:0] chroma_clamp(input logic signed [16:0] s);
        logic signed [8:0] sh;
        logic signed [9:0] t;
        logic [7:0] r;
        begin
            sh = 9'(s >>> 8);
            t  = 10'sd128 + 10'(sh);
            if (t < $signed({2'b00, CHROMA_MIN}))
            begin
                r = CHROMA_MIN;
            end
            else if (t > $signed({2'b00, CHROMA_MAX}))
            begin
                r = CHROMA_MAX;
            end
            else
            begin
                r = t[7:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- src/bgra_to_ycbcr420_converter_top.sv -----
// ----------------------------------------------------------------------------
// bgra_to_ycbcr420_converter_top
// raster pixel stream to bt.601 video range luma per pixel and 4:2:0 chroma
// ----------------------------------------------------------------------------
// One pixel is taken every clock unless pixel_stall is high. A taken pixel
// sits in the input register beside its registered line store read. Luma,
// the 2x2 averages, the chroma products and the clamping are then done in
// one pass into the result register. A stalled result holds both registers,
// but an empty input register still fills, so the sustained rate is one pixel
// per clock while the receiver does not stall. Horizontal pair sums
// of even rows sit in a 2048 x 27 line store with one write and one
// registered read port; odd rows read them back at odd columns to finish each
// 2x2 block. The store is not cleared after reset.
// frame_width sits at byte address 0 and frame_height at 4; the user must
// write both only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgra_to_ycbcr420_converter_top
    import b2y_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         luma,
    output logic               chroma_valid,
    output logic [7:0]         cb_out,
    output logic [7:0]         cr_out,
    output logic               frame_end
);

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_wr;
    reg_index_t       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline enables
    logic s1_v_reg, out_v_reg;
    logic en1, en_out;
    logic in_acc;

    assign en_out      = !out_v_reg || !result_stall;
    assign en1         = !s1_v_reg || en_out;
    assign pixel_stall = !en1;
    assign in_acc      = pixel_valid && en1;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic             row_end, frame_last;

    assign w_eff      = effective_size(frame_width_reg, WIDTH_MAX);
    assign h_eff      = effective_size(frame_height_reg, HEIGHT_MAX);
    assign row_end    = (CFG_W'(col_reg) + CFG_W'(1)) >= w_eff;
    assign frame_last = row_end && ((CFG_W'(row_reg) + CFG_W'(1)) >= h_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // even column hold and pair sums
    logic [7:0]       hold_b_reg, hold_g_reg, hold_r_reg;
    logic [SUM_W-1:0] pair_b, pair_g, pair_r;
    logic             odd_col, odd_row;
    logic             wr_en;
    logic [LINE_W-1:0] line_rd;

    assign odd_col = col_reg[0];
    assign odd_row = row_reg[0];
    assign pair_b  = SUM_W'(hold_b_reg) + SUM_W'(blue);
    assign pair_g  = SUM_W'(hold_g_reg) + SUM_W'(green);
    assign pair_r  = SUM_W'(hold_r_reg) + SUM_W'(red);
    assign wr_en   = in_acc && odd_col && !odd_row;

    always_ff @(posedge clk)
    begin
        if (in_acc && !odd_col)
        begin
            hold_b_reg <= blue;
            hold_g_reg <= green;
            hold_r_reg <= red;
        end
    end

    b2y_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (col_reg[COL_W-1:1]),
        .wr_data ({pair_b, pair_g, pair_r}),
        .rd_en   (en1),
        .rd_addr (col_reg[COL_W-1:1]),
        .rd_data (line_rd)
    );

    // stage 1: accepted pixel
    logic [7:0]       s1_b_reg, s1_g_reg, s1_r_reg;
    logic [SUM_W-1:0] s1_sb_reg, s1_sg_reg, s1_sr_reg;
    logic             s1_cv_reg, s1_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_b_reg    <= blue;
            s1_g_reg    <= green;
            s1_r_reg    <= red;
            s1_sb_reg   <= pair_b;
            s1_sg_reg   <= pair_g;
            s1_sr_reg   <= pair_r;
            s1_cv_reg   <= odd_col && odd_row;
            s1_fend_reg <= frame_last;
        end
    end

    // luma sum and clamp
    logic [15:0] luma_sum;
    logic [8:0]  luma_raw;
    logic [7:0]  luma_next;

    assign luma_sum  = 16'd66 * 16'(s1_r_reg) + 16'd129 * 16'(s1_g_reg)
                     + 16'd25 * 16'(s1_b_reg) + 16'd128;
    assign luma_raw  = 9'd16 + 9'(luma_sum[15:8]);
    assign luma_next = (luma_raw > 9'(LUMA_MAX)) ? LUMA_MAX :
                       (luma_raw < 9'(LUMA_MIN)) ? LUMA_MIN : luma_raw[7:0];

    // 2x2 averages and chroma sums
    logic [SUM_W:0]     blk_b, blk_g, blk_r;
    logic [7:0]         avg_b, avg_g, avg_r;
    logic signed [16:0] ab_s, ag_s, ar_s;
    logic signed [16:0] cb_sum, cr_sum;

    assign blk_b = (SUM_W+1)'(s1_sb_reg) + (SUM_W+1)'(line_rd[3*SUM_W-1:2*SUM_W]);
    assign blk_g = (SUM_W+1)'(s1_sg_reg) + (SUM_W+1)'(line_rd[2*SUM_W-1:SUM_W]);
    assign blk_r = (SUM_W+1)'(s1_sr_reg) + (SUM_W+1)'(line_rd[SUM_W-1:0]);
    assign avg_b = blk_b[SUM_W:2];
    assign avg_g = blk_g[SUM_W:2];
    assign avg_r = blk_r[SUM_W:2];

    assign ab_s = signed'(17'(avg_b));
    assign ag_s = signed'(17'(avg_g));
    assign ar_s = signed'(17'(avg_r));

    assign cb_sum = 17'sd112 * ab_s - 17'sd38 * ar_s - 17'sd74 * ag_s + 17'sd128;
    assign cr_sum = 17'sd112 * ar_s - 17'sd94 * ag_s - 17'sd18 * ab_s + 17'sd128;

    // result register
    logic [7:0] luma_reg, cb_reg, cr_reg;
    logic       cv_reg, fend_reg;
    logic [7:0] cb_next, cr_next;

    assign cb_next = s1_cv_reg ? chroma_clamp(cb_sum) : 8'd0;
    assign cr_next = s1_cv_reg ? chroma_clamp(cr_sum) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            luma_reg <= luma_next;
            cb_reg   <= cb_next;
            cr_reg   <= cr_next;
            cv_reg   <= s1_cv_reg;
            fend_reg <= s1_fend_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign luma         = luma_reg;
    assign chroma_valid = cv_reg;
    assign cb_out       = cb_reg;
    assign cr_out       = cr_reg;
    assign frame_end    = fend_reg;

    `B2Y_ASSERT(a_line_wr_even_row, clk, rst_n, wr_en |-> (col_reg[0] && !row_reg[0]),
        "line store written outside an even row odd column")
    `B2Y_ASSERT(a_frame_wrap, clk, rst_n,
        (in_acc && frame_last) |=> (col_reg == '0 && row_reg == '0),
        "position did not wrap at frame end")
    `B2Y_ASSERT(a_chroma_range, clk, rst_n,
        (out_v_reg && cv_reg) |-> (cb_reg >= CHROMA_MIN && cb_reg <= CHROMA_MAX
            && cr_reg >= CHROMA_MIN && cr_reg <= CHROMA_MAX),
        "chroma out of video range")
    `B2Y_ASSERT(a_chroma_zero, clk, rst_n,
        (out_v_reg && !cv_reg) |-> (cb_reg == 8'd0 && cr_reg == 8'd0),
        "chroma not zero without a completed block")
    `B2Y_ASSERT_NEVER(a_luma_range, clk, rst_n,
        out_v_reg && (luma_reg < LUMA_MIN || luma_reg > LUMA_MAX),
        "luma out of video range")

endmodule

// ----- src/b2y_ram.sv -----
// ----------------------------------------------------------------------------
// b2y_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module b2y_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- dv/bgra_to_ycbcr420_converter_top_test.sv -----
// ----------------------------------------------------------------------------
// bgra_to_ycbcr420_converter_top_test
// self-checking bench for the bgra to ycbcr 4:2:0 converter
// ----------------------------------------------------------------------------
// Pixels go in over the valid/stall input channel and every accepted pixel is
// run through a local copy of the luma and 2x2 chroma arithmetic, including
// the row and frame counters and the pair sum line store. Each result
// transfer is compared with the oldest predicted result. A directed part hits
// the color extremes, clamping and trailing odd rows and columns. Random
// phases then change frame size, including out-of-range sizes and changes in
// the middle of a frame, under several idle and stall patterns, with one long
// receiver hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module bgra_to_ycbcr420_converter_top_test
    import b2y_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASES        = 10;
    localparam int PHASE_PIXELS  = 40;
    localparam int LONG_HOLD     = 60;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [23:0] DIRECTED_BGR [25] = '{
        24'hFF0000, 24'hFF0000, 24'h0000FF, 24'h0000FF,
        24'hFF0000, 24'hFF0000, 24'h0000FF, 24'h0000FF,
        24'h00FFFF, 24'h00FFFF, 24'hFFFF00, 24'hFFFF00,
        24'h00FFFF, 24'h00FFFF, 24'hFFFF00, 24'hFFFF00,
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h00FF00, 24'hFF00FF, 24'h000000
    };

    // negative entries pick a small random size
    localparam int PHASE_WIDTH  [PHASES] = '{6, 0, 2, 8191, 5, 4096, 1, 3, -1, -1};
    localparam int PHASE_HEIGHT [PHASES] = '{4, 3, 0, 2, 8191, 1, 4096, 5, -1, -1};

    typedef struct packed
    {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       frame_end;
    } ycc_result_t;

    class ycc420_tracker_t;
        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        int unsigned       col;
        int unsigned       row;
        logic [7:0]        held_b;
        logic [7:0]        held_g;
        logic [7:0]        held_r;
        logic [LINE_W-1:0] pair_line [LINE_DEPTH];
        bit                line_written [LINE_DEPTH];
        ycc_result_t       expected_ycc [$];
        int                errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col        = 0;
            row        = 0;
            held_b     = '0;
            held_g     = '0;
            held_r     = '0;
            errors     = 0;
            foreach (line_written[i])
            begin
                line_written[i] = 1'b0;
                pair_line[i]    = '0;
            end
        endfunction

        function int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned maxv);
            if (v == '0)
            begin
                return 1;
            end
            if (v > maxv)
            begin
                return maxv;
            end
            return v;
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function void write_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_FRAME_WIDTH)
            begin
                width_reg = value[CFG_W-1:0];
            end
            else
            begin
                height_reg = value[CFG_W-1:0];
            end
        endfunction

        // a new width must never make an odd row read a line entry never written
        function bit width_is_safe(logic [CFG_W-1:0] value);
            int unsigned w;
            int unsigned need;
            int          i;
            w = size_in_use(value, MAX_WIDTH);
            if (row % 2 == 0)
            begin
                return 1'b1;
            end
            need = (((w > col + 1) ? w : col + 1) + 1) / 2;
            for (i = 0; i < need; i++)
            begin
                if (!line_written[i])
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function int unsigned pixels_left_in_row();
            int unsigned w;
            w = size_in_use(width_reg, MAX_WIDTH);
            return (col + 1 >= w) ? 1 : w - col;
        endfunction

        function void add_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            ycc_result_t e;
            int unsigned w;
            int unsigned h;
            int unsigned y;
            int unsigned sb;
            int unsigned sg;
            int unsigned sr;
            int unsigned idx;
            int          ab;
            int          ag;
            int          ar;
            e = '0;
            w = size_in_use(width_reg, MAX_WIDTH);
            h = size_in_use(height_reg, MAX_HEIGHT);
            y = 16 + ((66 * r + 129 * g + 25 * b + 128) >> 8);
            e.luma = 8'(clip(int'(y), LUMA_MIN, LUMA_MAX));
            if (col % 2 == 0)
            begin
                held_b = b;
                held_g = g;
                held_r = r;
            end
            else
            begin
                sb  = held_b + b;
                sg  = held_g + g;
                sr  = held_r + r;
                idx = col / 2;
                if (idx < LINE_DEPTH)
                begin
                    if (row % 2 == 0)
                    begin
                        pair_line[idx]    = {sb[8:0], sg[8:0], sr[8:0]};
                        line_written[idx] = 1'b1;
                    end
                    else
                    begin
                        ab = int'((sb + pair_line[idx][26:18]) >> 2);
                        ag = int'((sg + pair_line[idx][17:9]) >> 2);
                        ar = int'((sr + pair_line[idx][8:0]) >> 2);
                        e.cb = 8'(clip(128 + ((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8),
                                       CHROMA_MIN, CHROMA_MAX));
                        e.cr = 8'(clip(128 + ((112 * ar - 94 * ag - 18 * ab + 128) >>> 8),
                                       CHROMA_MIN, CHROMA_MAX));
                        e.chroma_valid = 1'b1;
                    end
                end
            end
            if (col + 1 >= w)
            begin
                e.frame_end = (row + 1 >= h);
                col = 0;
                row = e.frame_end ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
            expected_ycc.push_back(e);
        endfunction

        function void check_result(ycc_result_t got);
            ycc_result_t e;
            if (expected_ycc.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with no pixel pending, luma %0d",
                         $time, got.luma);
                return;
            end
            e = expected_ycc.pop_front();
            if (got !== e)
            begin
                errors++;
                $display("%0t: result mismatch, expected y %0d cv %0b cb %0d cr %0d fe %0b,",
                         $time, e.luma, e.chroma_valid, e.cb, e.cr, e.frame_end,
                         " got y %0d cv %0b cb %0d cr %0d fe %0b",
                         got.luma, got.chroma_valid, got.cb, got.cr, got.frame_end);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               pixel_valid;
    logic               pixel_stall;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               result_valid;
    logic               result_stall;
    logic [7:0]         luma;
    logic               chroma_valid;
    logic [7:0]         cb_out;
    logic [7:0]         cr_out;
    logic               frame_end;

    ycc420_tracker_t tracker = new();

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    bgra_to_ycbcr420_converter_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .luma         (luma),
        .chroma_valid (chroma_valid),
        .cb_out       (cb_out),
        .cr_out       (cr_out),
        .frame_end    (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver side, with the long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                tracker.check_result(ycc_result_t'({luma, chroma_valid, cb_out, cr_out,
                                                    frame_end}));
            end
            if (pixel_valid && !pixel_stall)
            begin
                tracker.add_pixel(blue, green, red);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (psel && penable))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic apb_write(reg_index_t idx, logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] data;
        data = PDATA_W'($urandom());
        data[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        blue        <= b;
        green       <= g;
        red         <= r;
        do @(posedge clk); while (pixel_stall);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0)
        begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom());
    endfunction

    task automatic send_random_pixel();
        send_pixel(pick_byte(), pick_byte(), pick_byte());
    endtask

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (tracker.expected_ycc.size() != 0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int               i;
        int               p;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pixel_valid    = 1'b0;
        blue           = '0;
        green          = '0;
        red            = '0;
        result_stall   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // solid 2x2 blocks of primaries and secondaries, then a 3x3 frame
        apb_write(REG_FRAME_WIDTH, CFG_W'(4));
        apb_write(REG_FRAME_HEIGHT, CFG_W'(2));
        for (i = 0; i < 16; i++)
        begin
            send_pixel(DIRECTED_BGR[i][23:16], DIRECTED_BGR[i][15:8], DIRECTED_BGR[i][7:0]);
        end
        wait_drained();
        apb_write(REG_FRAME_WIDTH, CFG_W'(3));
        apb_write(REG_FRAME_HEIGHT, CFG_W'(3));
        for (i = 16; i < 25; i++)
        begin
            send_pixel(DIRECTED_BGR[i][23:16], DIRECTED_BGR[i][15:8], DIRECTED_BGR[i][7:0]);
        end
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            w = (PHASE_WIDTH[p] < 0) ? CFG_W'($urandom_range(1, 16)) : CFG_W'(PHASE_WIDTH[p]);
            h = (PHASE_HEIGHT[p] < 0) ? CFG_W'($urandom_range(1, 8)) : CFG_W'(PHASE_HEIGHT[p]);
            if (!tracker.width_is_safe(w))
            begin
                repeat (tracker.pixels_left_in_row()) send_random_pixel();
                wait_drained();
            end
            apb_write(REG_FRAME_WIDTH, w);
            apb_write(REG_FRAME_HEIGHT, h);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            if (p == 4)
            begin
                hold_request = 1'b1;
            end
            repeat (PHASE_PIXELS) send_random_pixel();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_ycc.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- bgra_to_ycbcr420_converter_top.f -----
+incdir+src
src/b2y_pkg.sv
src/b2y_ram.sv
src/bgra_to_ycbcr420_converter_top.sv
dv/bgra_to_ycbcr420_converter_top_test.sv
